@@ rtl/core/packed_cholesky_factorizer_unit_assert.svh @@
// assertion macros for the packed cholesky factoriser
`ifndef PACKED_CHOLESKY_FACTORIZER_UNIT_ASSERT_SVH
`define PACKED_CHOLESKY_FACTORIZER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PCF_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PCF_ASSERT_NOW(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PCF_ASSERT_IMPL(label, clk, rst_n, prop)
`define PCF_ASSERT_NOW(label, clk, prop)
`endif
`endif

@@ rtl/core/pcf_pkg.sv @@
// shared types and constants of the packed cholesky factoriser
`timescale 1ns / 1ps
package pcf_pkg;
    // element and factor width, signed q16.16
    localparam int VALUE_WIDTH = 32;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_RD_A,
        ST_RD_B,
        ST_MUL,
        ST_ACC,
        ST_START_OP,
        ST_WAIT_OP,
        ST_WRITE,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_SQRT,
        OP_DIV
    } t_op;
endpackage

@@ rtl/core/pcf_ram.sv @@
// generic single-port ram with registered read
`timescale 1ns / 1ps
module pcf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 36
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                              i_wdata,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

@@ rtl/core/pcf_arith.sv @@
// multi-cycle square root and saturating divide, one result bit per cycle
`timescale 1ns / 1ps
module pcf_arith #(
    parameter int VW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  pcf_pkg::t_op         i_op,
    input  logic signed [VW+31:0] i_s,
    input  logic signed [VW-1:0] i_d,
    output logic                 o_done,
    output logic [VW-1:0]        o_result
);
    import pcf_pkg::*;

    localparam int SW = VW + 32;
    localparam int RW = 2 * SW;
    localparam int CW = $clog2(SW + 2);

    logic          r_busy;
    t_op           r_op;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_rad;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [SW-1:0] r_den;
    logic          r_neg;
    logic          r_sat;

    logic [SW-1:0] mag_s;
    logic [VW-1:0] mag_d;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] dshift;
    logic [RW-1:0] num;
    logic [RW-1:0] n_rem;
    logic [RW-1:0] n_root;
    logic [RW-1:0] n_rad;

    assign mag_s = i_s[SW-1] ? SW'(-i_s) : SW'(i_s);
    assign mag_d = i_d[VW-1] ? VW'(-i_d) : VW'(i_d);
    assign num   = {{(RW-SW){1'b0}}, mag_s} << 16;
    assign dshift = {{(RW-VW){1'b0}}, mag_d} << 15;

    // restoring steps: root takes two radicand bits, divide takes one
    always_comb begin
        n_rem  = r_rem;
        n_root = r_root;
        n_rad  = r_rad;
        rem_sh = '0;
        trial  = '0;
        if (r_op == OP_SQRT) begin
            rem_sh = {r_rem[RW-3:0], r_rad[RW-1 -: 2]};
            trial  = {r_root[RW-3:0], 2'b01};
            n_rad  = {r_rad[RW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[RW-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[RW-2:0], 1'b0};
            end
        end else begin
            rem_sh = {r_rem[RW-2:0], r_rad[RW-1]};
            trial  = {{(RW-SW){1'b0}}, r_den};
            n_rad  = {r_rad[RW-2:0], 1'b0};
            if (rem_sh >= trial) begin
                n_rem  = rem_sh - trial;
                n_root = {r_root[RW-2:0], 1'b1};
            end else begin
                n_rem  = rem_sh;
                n_root = {r_root[RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_op   <= i_op;
                r_rem  <= '0;
                r_root <= '0;
                r_rad  <= num;
                r_den  <= SW'(mag_d);
                r_neg  <= i_s[SW-1] ^ i_d[VW-1];
                r_sat  <= ({{(RW-SW){1'b0}}, mag_s} >= dshift);
                r_cnt  <= (i_op == OP_SQRT) ? CW'(SW) : CW'(RW - 1);
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_root <= n_root;
                r_rad  <= n_rad;
                if (r_op == OP_DIV && r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else if (r_op == OP_SQRT && r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    // quotient clamp mirrors the signed output range
    always_comb begin
        if (r_op == OP_SQRT) begin
            o_result = r_root[VW-1:0];
        end else if (r_sat || r_root[RW-1:VW-1] != '0) begin
            o_result = r_neg ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            o_result = r_neg ? VW'(-r_root[VW-1:0]) : r_root[VW-1:0];
        end
    end
endmodule

@@ rtl/core/packed_cholesky_factorizer_unit.sv @@
// top level of the packed cholesky factoriser
`timescale 1ns / 1ps
`include "packed_cholesky_factorizer_unit_assert.svh"
// loading: one element per cycle, busy stays low until the final element transfer
// per factor entry: ST_RD_A, then ST_RD_B, ST_MUL, ST_ACC and ST_WRITE for each
// product over k, then ST_START_OP starts a root or a divide (none on a failed
// pivot or zero divisor) and its result, or zero, is written; emission: a read in
// ST_EMIT_RD, then n(n+1)/2 results on consecutive cycles
// reset: synchronous active low, order returns to 8 and the load count to zero;
// results cannot be stalled by the receiver
module packed_cholesky_factorizer_unit #(
    parameter int MAX_ORDER   = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [pcf_pkg::VALUE_WIDTH-1:0] i_element_value,
    input  logic                                   i_cfg_we,
    input  logic [3:0]                             i_cfg_wdata,
    output logic                                   o_strobe,
    output logic [2:0]                             o_row,
    output logic [2:0]                             o_col,
    output logic signed [pcf_pkg::VALUE_WIDTH-1:0] o_factor_value,
    output logic                                   o_not_positive,
    output logic                                   o_last
);
    import pcf_pkg::*;

    localparam int DEPTH = MAX_ORDER * (MAX_ORDER + 1) / 2;
    localparam int AW    = $clog2(DEPTH + 1);
    localparam int MW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = $clog2(MAX_ORDER + 1);
    localparam int VW    = VALUE_WIDTH;
    localparam int SW    = VW + 32;

    t_state r_state, n_state;
    logic [3:0]    r_size;
    logic [AW-1:0] r_cnt;
    logic          r_fail;
    logic [IW-1:0] r_i, r_j, r_k;
    logic [IW-1:0] n_i, n_j, n_k;
    logic signed [SW-1:0] r_s, n_s;
    logic signed [VW-1:0] r_a;
    logic signed [2*VW-1:0] r_p;
    logic signed [VW-1:0] r_diag;
    logic [IW-1:0]  eff_n;
    logic [AW-1:0]  total;

    // matrix store holds the input, factor store the results
    logic          a_we, f_we;
    logic [MW-1:0] a_addr, f_addr;
    logic [VW-1:0] a_rdata, f_rdata, f_wdata;

    logic          op_start, op_done;
    t_op           op_sel;
    logic [VW-1:0] op_res;
    logic          accept;

    function automatic logic [AW-1:0] tri_idx(input logic [IW-1:0] i, input logic [IW-1:0] j);
        tri_idx = AW'((32'(i) * (32'(i) + 32'd1)) >> 1) + AW'(j);
    endfunction

    function automatic logic [MW-1:0] tri_addr(input logic [IW-1:0] i,
                                               input logic [IW-1:0] j);
        tri_addr = MW'(tri_idx(i, j));
    endfunction

    always_comb begin
        if (r_size == 4'd0) begin
            eff_n = IW'(1);
        end else if (32'(r_size) > MAX_ORDER) begin
            eff_n = IW'(MAX_ORDER);
        end else begin
            eff_n = IW'(r_size);
        end
        total = AW'((32'(eff_n) * (32'(eff_n) + 32'd1)) >> 1);
    end

    assign busy   = (r_state != ST_LOAD);
    assign accept = start && !busy;

    pcf_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_mat (
        .i_clk(i_clk), .i_we(a_we), .i_addr(a_addr),
        .i_wdata(i_element_value), .o_rdata(a_rdata)
    );
    pcf_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_fac (
        .i_clk(i_clk), .i_we(f_we), .i_addr(f_addr),
        .i_wdata(f_wdata), .o_rdata(f_rdata)
    );
    pcf_arith #(.VW(VW)) u_arith (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(op_start), .i_op(op_sel),
        .i_s(r_s), .i_d(r_diag), .o_done(op_done), .o_result(op_res)
    );

    logic [AW-1:0] load_idx;
    assign load_idx = (r_cnt >= total) ? '0 : r_cnt;
    logic [AW-1:0] emit_idx;
    assign emit_idx = tri_idx(r_i, r_j);

    // next state and memory control
    always_comb begin
        n_state  = r_state;
        n_i = r_i; n_j = r_j; n_k = r_k; n_s = r_s;
        a_we = 1'b0; f_we = 1'b0;
        a_addr = '0; f_addr = '0; f_wdata = op_res;
        op_start = 1'b0;
        op_sel = (r_i == r_j) ? OP_SQRT : OP_DIV;
        case (r_state)
            ST_LOAD: begin
                a_we   = accept;
                a_addr = load_idx[MW-1:0];
                if (accept && load_idx + AW'(1) == total) begin
                    n_state = ST_RD_A;
                    n_i = '0; n_j = '0;
                end
            end
            ST_RD_A: begin
                // element a[i][j]; also fetch L[j][j] for the divide
                a_addr  = emit_idx[MW-1:0];
                f_addr  = tri_addr(r_j, r_j);
                n_k     = '0;
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                if (r_k == '0) begin
                    n_s = SW'(signed'(a_rdata));
                end
                if (r_k == r_j) begin
                    n_state = ST_START_OP;
                end else begin
                    f_addr  = tri_addr(r_i, r_k);
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                f_addr  = tri_addr(r_j, r_k);
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                // subtract the rounded product and step k
                n_s = r_s - SW'((r_p + (2*VW)'(32768)) >>> 16);
                n_k = r_k + IW'(1);
                n_state = ST_RD_B;
            end
            ST_START_OP: begin
                if (r_i == r_j && r_s <= 0) begin
                    f_we = 1'b1; f_wdata = '0;
                    f_addr = emit_idx[MW-1:0];
                    n_state = ST_EMIT_RD;
                end else if (r_i != r_j && r_diag == '0) begin
                    f_we = 1'b1; f_wdata = '0;
                    f_addr = emit_idx[MW-1:0];
                    n_state = ST_EMIT_RD;
                end else begin
                    op_start = 1'b1;
                    n_state  = ST_WAIT_OP;
                end
            end
            ST_WAIT_OP: begin
                if (op_done) begin
                    f_we = 1'b1;
                    f_addr = emit_idx[MW-1:0];
                    n_state = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                // advance entry; after the last, start reading for emission
                if (r_j == r_i) begin
                    if (r_i == eff_n - IW'(1)) begin
                        n_i = '0; n_j = '0;
                        f_addr = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_i = r_i + IW'(1); n_j = '0;
                        n_state = ST_RD_A;
                    end
                end else begin
                    n_j = r_j + IW'(1);
                    n_state = ST_RD_A;
                end
            end
            ST_EMIT: begin
                if (r_j == r_i) begin
                    n_i = r_i + IW'(1); n_j = '0;
                end else begin
                    n_j = r_j + IW'(1);
                end
                if (r_i == eff_n - IW'(1) && r_j == r_i) begin
                    n_state = ST_LOAD;
                end else begin
                    f_addr = tri_addr(n_i, n_j);
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_LOAD;
            r_size   <= 4'd8;
            r_cnt    <= '0;
            r_fail   <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= (r_state == ST_EMIT);
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
                r_cnt  <= '0;
            end else if (accept) begin
                r_cnt <= (load_idx + AW'(1) == total) ? '0 : load_idx + AW'(1);
            end
            if (r_state == ST_LOAD && n_state == ST_RD_A) begin
                r_fail <= 1'b0;
            end else if (r_state == ST_START_OP && r_i == r_j && r_s <= 0) begin
                r_fail <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_k <= n_k; r_s <= n_s;
        if (r_state == ST_RD_B && r_k == '0) begin
            r_diag <= signed'(f_rdata);
        end
        if (r_state == ST_MUL) begin
            r_a <= signed'(f_rdata);
        end
        if (r_state == ST_WRITE) begin
            r_p <= '0;
        end
        if (r_state == ST_ACC) begin
            r_p <= r_a * signed'(f_rdata);
        end
        // factor entry read for this emission slot lands with its indices
        if (r_state == ST_EMIT) begin
            o_factor_value <= signed'(f_rdata);
        end
        o_row          <= 3'(r_i);
        o_col          <= 3'(r_j);
        o_not_positive <= r_fail;
        o_last         <= (r_i == eff_n - IW'(1)) && (r_j == r_i);
    end

    `PCF_ASSERT_IMPL(a_col_le_row, i_clk, i_rst_n, o_strobe |-> (o_col <= o_row))
    `PCF_ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, busy |-> !(r_state == ST_LOAD))
    `PCF_ASSERT_IMPL(a_last_ends, i_clk, i_rst_n, (o_strobe && o_last) |=> !o_strobe)
endmodule
